// ===== design/ltps_pkg.sv =====
// Shared types, constants and character classes for the line token pattern scanner.
`timescale 1ns / 1ps
`default_nettype none

package ltps_pkg;

  // Line counter width default
  localparam int LINE_NUMBER_BITS_DEF = 32;

  // Field widths
  localparam int RUN_BITS      = 6;
  localparam int LINE_OUT_BITS = 32;
  localparam int OUT_DATA_BITS = 40;

  // Configuration reset values
  localparam logic [2:0]          ENABLE_RST   = 3'd7;
  localparam logic [RUN_BITS-1:0] GHP_LEN_RST  = 6'd36;
  localparam logic [RUN_BITS-1:0] HF_LEN_RST   = 6'd30;
  localparam logic [RUN_BITS-1:0] AKIA_LEN_RST = 6'd16;

  // Characters of interest
  localparam logic [7:0] CH_NEWLINE = 8'h0a;
  localparam logic [7:0] CH_LOW_G   = 8'h67;
  localparam logic [7:0] CH_LOW_H   = 8'h68;
  localparam logic [7:0] CH_LOW_P   = 8'h70;
  localparam logic [7:0] CH_LOW_F   = 8'h66;
  localparam logic [7:0] CH_UNDER   = 8'h5f;
  localparam logic [7:0] CH_UP_A    = 8'h41;
  localparam logic [7:0] CH_UP_K    = 8'h4b;
  localparam logic [7:0] CH_UP_I    = 8'h49;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_PATTERN_ENABLE  = 2'd0,
    CFG_GHP_RUN_LENGTH  = 2'd1,
    CFG_HF_MIN_RUN      = 2'd2,
    CFG_AKIA_RUN_LENGTH = 2'd3
  } cfg_index_t;

  // Pattern hit bit positions
  localparam int HIT_GHP  = 0;
  localparam int HIT_HF   = 1;
  localparam int HIT_AKIA = 2;

  // Control from the top level to the matchers
  typedef struct packed {
    logic advance;  // ordinary byte accepted
    logic clear;    // newline or end of file accepted
  } match_ctl_t;

  // Run lengths required by each pattern
  typedef struct packed {
    logic [RUN_BITS-1:0] ghp;
    logic [RUN_BITS-1:0] hf;
    logic [RUN_BITS-1:0] akia;
  } run_need_t;

  function automatic logic is_digit(input logic [7:0] c);
    is_digit = (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_upper(input logic [7:0] c);
    is_upper = (c >= 8'h41) && (c <= 8'h5a);
  endfunction

  function automatic logic is_lower(input logic [7:0] c);
    is_lower = (c >= 8'h61) && (c <= 8'h7a);
  endfunction

endpackage

`default_nettype wire

// ===== design/ltps_matchers.sv =====
// Prefix matchers and run counters for the three token patterns.
`timescale 1ns / 1ps
`default_nettype none

module ltps_matchers (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire ltps_pkg::match_ctl_t    ctl,
  input  wire logic [7:0]              byte_value,
  input  wire ltps_pkg::run_need_t     need,
  output logic [2:0]                   hit
);

  localparam logic [ltps_pkg::RUN_BITS-1:0] RUN_MAX = '1;

  logic [2:0] ghp_prog_r, ghp_prog_nxt;
  logic [1:0] hf_prog_r, hf_prog_nxt;
  logic [1:0] akia_prog_r, akia_prog_nxt;
  logic [ltps_pkg::RUN_BITS-1:0] ghp_cnt_r, ghp_cnt_nxt;
  logic [ltps_pkg::RUN_BITS-1:0] hf_cnt_r, hf_cnt_nxt;
  logic [ltps_pkg::RUN_BITS-1:0] akia_cnt_r, akia_cnt_nxt;
  logic ghp_act_r, ghp_act_nxt;
  logic hf_act_r, hf_act_nxt;
  logic akia_act_r, akia_act_nxt;
  logic ghp_done, hf_done, akia_done;
  logic alnum, akia_class;

  assign alnum      = ltps_pkg::is_digit(byte_value) || ltps_pkg::is_upper(byte_value)
                   || ltps_pkg::is_lower(byte_value);
  assign akia_class = ltps_pkg::is_digit(byte_value) || ltps_pkg::is_upper(byte_value);

  // Step the "ghp_" prefix matcher
  always_comb begin
    ghp_done     = 1'b0;
    ghp_prog_nxt = (byte_value == ltps_pkg::CH_LOW_G) ? 3'd1 : 3'd0;
    case (ghp_prog_r)
      3'd0: if (byte_value == ltps_pkg::CH_LOW_G) ghp_prog_nxt = 3'd1;
      3'd1: if (byte_value == ltps_pkg::CH_LOW_H) ghp_prog_nxt = 3'd2;
      3'd2: if (byte_value == ltps_pkg::CH_LOW_P) ghp_prog_nxt = 3'd3;
      3'd3: if (byte_value == ltps_pkg::CH_UNDER) begin
        ghp_prog_nxt = 3'd0;
        ghp_done     = 1'b1;
      end
      default: ;
    endcase
  end

  // Step the "hf_" prefix matcher
  always_comb begin
    hf_done     = 1'b0;
    hf_prog_nxt = (byte_value == ltps_pkg::CH_LOW_H) ? 2'd1 : 2'd0;
    case (hf_prog_r)
      2'd0: if (byte_value == ltps_pkg::CH_LOW_H) hf_prog_nxt = 2'd1;
      2'd1: if (byte_value == ltps_pkg::CH_LOW_F) hf_prog_nxt = 2'd2;
      2'd2: if (byte_value == ltps_pkg::CH_UNDER) begin
        hf_prog_nxt = 2'd0;
        hf_done     = 1'b1;
      end
      default: ;
    endcase
  end

  // Step the "AKIA" prefix matcher; its border "A" restarts at one
  always_comb begin
    akia_done     = 1'b0;
    akia_prog_nxt = (byte_value == ltps_pkg::CH_UP_A) ? 2'd1 : 2'd0;
    case (akia_prog_r)
      2'd1: if (byte_value == ltps_pkg::CH_UP_K) akia_prog_nxt = 2'd2;
      2'd2: if (byte_value == ltps_pkg::CH_UP_I) akia_prog_nxt = 2'd3;
      2'd3: akia_done = (byte_value == ltps_pkg::CH_UP_A);
      default: ;
    endcase
  end

  // Advance the run counters: extend a live run, else restart on a finished prefix
  always_comb begin
    ghp_act_nxt = ghp_done;
    ghp_cnt_nxt = '0;
    if (ghp_act_r && alnum) begin
      ghp_act_nxt = 1'b1;
      ghp_cnt_nxt = (ghp_cnt_r == RUN_MAX) ? ghp_cnt_r : ghp_cnt_r + 1'b1;
    end
    hf_act_nxt = hf_done;
    hf_cnt_nxt = '0;
    if (hf_act_r && alnum) begin
      hf_act_nxt = 1'b1;
      hf_cnt_nxt = (hf_cnt_r == RUN_MAX) ? hf_cnt_r : hf_cnt_r + 1'b1;
    end
    akia_act_nxt = akia_done;
    akia_cnt_nxt = '0;
    if (akia_act_r && akia_class) begin
      akia_act_nxt = 1'b1;
      akia_cnt_nxt = (akia_cnt_r == RUN_MAX) ? akia_cnt_r : akia_cnt_r + 1'b1;
    end
  end

  // Report runs that meet their length on this byte
  always_comb begin
    hit = '0;
    hit[ltps_pkg::HIT_GHP]  = ctl.advance && ghp_act_nxt && (ghp_cnt_nxt >= need.ghp);
    hit[ltps_pkg::HIT_HF]   = ctl.advance && hf_act_nxt && (hf_cnt_nxt >= need.hf);
    hit[ltps_pkg::HIT_AKIA] = ctl.advance && akia_act_nxt && (akia_cnt_nxt >= need.akia);
  end

  // Hold matcher state; clear at line and file ends
  always_ff @(posedge clk) begin
    if (!rst_n || ctl.clear) begin
      ghp_prog_r  <= '0;
      hf_prog_r   <= '0;
      akia_prog_r <= '0;
      ghp_cnt_r   <= '0;
      hf_cnt_r    <= '0;
      akia_cnt_r  <= '0;
      ghp_act_r   <= 1'b0;
      hf_act_r    <= 1'b0;
      akia_act_r  <= 1'b0;
    end else if (ctl.advance) begin
      ghp_prog_r  <= ghp_prog_nxt;
      hf_prog_r   <= hf_prog_nxt;
      akia_prog_r <= akia_prog_nxt;
      ghp_cnt_r   <= ghp_cnt_nxt;
      hf_cnt_r    <= hf_cnt_nxt;
      akia_cnt_r  <= akia_cnt_nxt;
      ghp_act_r   <= ghp_act_nxt;
      hf_act_r    <= hf_act_nxt;
      akia_act_r  <= akia_act_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== design/line_token_pattern_scanner_unit.sv =====
// Top level of the line token pattern scanner: line tracking, configuration and result buffer.
`timescale 1ns / 1ps
`default_nettype none

// Scans a file one byte per beat at one beat per clock while the result buffer has room.
// Each byte updates three prefix matchers and their run counters in the cycle it is
// accepted; a newline beat, or an end-of-file beat (in_tlast, data ignored), yields one
// result beat that is registered into the output buffer on acceptance. Results pass
// through a two-entry output buffer (result register plus skid register), so the input
// keeps flowing while a single result waits and stalls only when both entries are full.
// Configuration writes are always ready and should be made between files.
module line_token_pattern_scanner_unit #(
  parameter int LINE_NUMBER_BITS = ltps_pkg::LINE_NUMBER_BITS_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  // Input channel
  input  wire logic                                in_tvalid,
  output logic                                     in_tready,
  input  wire logic [7:0]                          in_tdata,   // [7:0] byte_value
  input  wire logic                                in_tlast,   // end_of_file
  // Result channel
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  // [31:0] line_number, [32] prefix_ghp_hit, [33] prefix_hf_hit,
  // [34] prefix_akia_hit, [35] file_has_secret, [39:36] zero
  output logic [ltps_pkg::OUT_DATA_BITS-1:0]       out_tdata,
  output logic                                     out_tuser,  // line_valid
  output logic                                     out_tlast,  // file_done
  // Configuration write channel
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire ltps_pkg::cfg_index_t                cfg_index,
  input  wire logic [ltps_pkg::RUN_BITS-1:0]       cfg_data
);

  localparam logic [LINE_NUMBER_BITS-1:0] LINE_MAX = '1;
  localparam logic [LINE_NUMBER_BITS-1:0] LINE_ONE = LINE_NUMBER_BITS'(1);
  localparam int RES_BITS = ltps_pkg::OUT_DATA_BITS + 2;

  logic [2:0]                    enable_r;
  ltps_pkg::run_need_t           need_r;
  logic [2:0]                    flags_r, flags_nxt;
  logic [LINE_NUMBER_BITS-1:0]   line_r;
  logic                          has_bytes_r;
  logic                          any_hit_r;
  logic                          in_fire, is_eof, is_nl, cfg_fire;
  logic                          produce;
  ltps_pkg::match_ctl_t          ctl;
  logic [2:0]                    hit;
  logic [RES_BITS-1:0]           res_nxt;
  logic [RES_BITS-1:0]           out_r, skid_r;
  logic                          out_valid_r, skid_valid_r;
  logic                          line_close;

  assign in_fire  = in_tvalid && in_tready;
  assign is_eof   = in_tlast;
  assign is_nl    = !in_tlast && (in_tdata == ltps_pkg::CH_NEWLINE);
  assign cfg_ready = 1'b1;
  assign cfg_fire = cfg_valid && cfg_ready;

  assign ctl.advance = in_fire && !is_eof && !is_nl;
  assign ctl.clear   = in_fire && (is_eof || is_nl);
  assign produce     = ctl.clear;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r    <= ltps_pkg::ENABLE_RST;
      need_r.ghp  <= ltps_pkg::GHP_LEN_RST;
      need_r.hf   <= ltps_pkg::HF_LEN_RST;
      need_r.akia <= ltps_pkg::AKIA_LEN_RST;
    end else if (cfg_fire) begin
      case (cfg_index)
        ltps_pkg::CFG_PATTERN_ENABLE:  enable_r    <= cfg_data[2:0];
        ltps_pkg::CFG_GHP_RUN_LENGTH:  need_r.ghp  <= cfg_data;
        ltps_pkg::CFG_HF_MIN_RUN:      need_r.hf   <= cfg_data;
        ltps_pkg::CFG_AKIA_RUN_LENGTH: need_r.akia <= cfg_data;
        default: ;
      endcase
    end
  end

  ltps_matchers u_matchers (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (ctl),
    .byte_value (in_tdata),
    .need       (need_r),
    .hit        (hit)
  );

  assign flags_nxt  = flags_r | (hit & enable_r);
  // A line closes on newline, or on end of file after a partial line
  assign line_close = is_nl || has_bytes_r;

  // Build the result beat from the state before this byte
  always_comb begin
    res_nxt = '0;
    if (line_close) begin
      res_nxt[ltps_pkg::LINE_OUT_BITS-1:0] = ltps_pkg::LINE_OUT_BITS'(line_r);
      res_nxt[ltps_pkg::LINE_OUT_BITS +: 3] = flags_r;
    end
    if (is_eof)
      res_nxt[ltps_pkg::LINE_OUT_BITS + 3] = any_hit_r || (|flags_r);
    res_nxt[RES_BITS-2] = line_close;  // line_valid
    res_nxt[RES_BITS-1] = is_eof;      // file_done
  end

  // Line and file tracking
  always_ff @(posedge clk) begin
    if (!rst_n || (in_fire && is_eof)) begin
      flags_r     <= '0;
      line_r      <= LINE_ONE;
      has_bytes_r <= 1'b0;
      any_hit_r   <= 1'b0;
    end else if (in_fire && is_nl) begin
      flags_r     <= '0;
      has_bytes_r <= 1'b0;
      any_hit_r   <= any_hit_r || (|flags_r);
      if (line_r != LINE_MAX) line_r <= line_r + LINE_ONE;
    end else if (ctl.advance) begin
      flags_r     <= flags_nxt;
      has_bytes_r <= 1'b1;
    end
  end

  // Two-entry result buffer: drain, refill from skid, or park a new beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_valid_r && out_tready) begin
      if (skid_valid_r) begin
        out_r        <= skid_r;
        skid_valid_r <= 1'b0;
      end else if (produce) begin
        out_r <= res_nxt;
      end else begin
        out_valid_r <= 1'b0;
      end
    end else if (!out_valid_r) begin
      if (produce) begin
        out_r       <= res_nxt;
        out_valid_r <= 1'b1;
      end
    end else if (produce) begin
      skid_r       <= res_nxt;
      skid_valid_r <= 1'b1;
    end
  end

  assign in_tready  = !skid_valid_r;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_r[ltps_pkg::OUT_DATA_BITS-1:0];
  assign out_tuser  = out_r[RES_BITS-2];
  assign out_tlast  = out_r[RES_BITS-1];

endmodule

`default_nettype wire
